@@ sv/kmt_pkg.sv @@
// ----------------------------------------------------------------------------
// kmt_pkg
// Shared types and constants of the keyboard matrix translator: channel
// payloads, the classified item passed from front to back, table layout.
// ----------------------------------------------------------------------------
`default_nettype none

package kmt_pkg;

   // command codes on the request channel
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   // idle row value (all keys up, active low)
   localparam logic [4:0] ROW_IDLE = 5'd31;

   // modifier key positions
   localparam int POS_LSHIFT     = 93;
   localparam int POS_RSHIFT     = 94;
   localparam int POS_CTRL_FIRST = 95;
   localparam int POS_CTRL_LAST  = 98;

   // table entry: {plain, shifted, control, both, flags}
   localparam int ENTRY_W = 40;
   localparam logic [ENTRY_W-1:0] ENTRY_RESET = 40'hFF_FF_FF_FF_00;

   typedef struct packed {
      logic       cmd;
      logic [6:0] key_index;
      logic       key_pressed;
      logic [7:0] map_plain;
      logic [7:0] map_shifted;
      logic [7:0] map_control;
      logic [7:0] map_both;
      logic [7:0] map_flags;
   } req_type;

   typedef struct packed {
      logic [4:0] row_0;
      logic [4:0] row_1;
      logic [4:0] row_2;
      logic [4:0] row_3;
      logic [4:0] row_4;
      logic [4:0] row_5;
      logic [4:0] row_6;
      logic [4:0] row_7;
   } rsp_type;

   // what the back end does with an item before its scan
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_LOAD = 2'd1,
      OP_KEY  = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [6:0]         key_index;
      logic               key_pressed;
      logic [ENTRY_W-1:0] entry;
   } item_type;

endpackage

`default_nettype wire

@@ sv/kmt_ram.sv @@
// ----------------------------------------------------------------------------
// kmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 105
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/kmt_front.sv @@
// ----------------------------------------------------------------------------
// kmt_front
// Input stage: accepts request items, classifies them as table load, key
// event or no-op (index out of range) and offers them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_front #(
   parameter int NUM_HOST_KEYS = 105
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire kmt_pkg::req_type  req_data,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output kmt_pkg::item_type      push_item
);

   import kmt_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     in_range;
   logic     take;

   // classify the incoming item
   always_comb begin
      in_range            = ({1'b0, req_data.key_index} < 8'(NUM_HOST_KEYS));
      item_in.key_index   = req_data.key_index;
      item_in.key_pressed = req_data.key_pressed;
      item_in.entry       = {req_data.map_plain, req_data.map_shifted,
                             req_data.map_control, req_data.map_both,
                             req_data.map_flags};
      if (!in_range) begin
         item_in.op = OP_NONE;
      end else if (req_data.cmd == CMD_LOAD) begin
         item_in.op = OP_LOAD;
      end else begin
         item_in.op = OP_KEY;
      end
   end

   // hold one item until the queue takes it
   assign req_ready = !vld_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      if (take) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = vld_ff;
   assign push_item  = item_ff;

endmodule

`default_nettype wire

@@ sv/kmt_queue.sv @@
// ----------------------------------------------------------------------------
// kmt_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire kmt_pkg::item_type  push_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output kmt_pkg::item_type       pop_item
);

   import kmt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/kmt_back.sv @@
// ----------------------------------------------------------------------------
// kmt_back
// Execution stage: applies a queued item to the held-key bits or the mapping
// table, then scans every table entry once to rebuild the matrix rows.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_back #(
   parameter int NUM_HOST_KEYS = 105
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire kmt_pkg::item_type  pop_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output kmt_pkg::rsp_type        rsp_data
);

   import kmt_pkg::*;

   localparam int IDX_W = $clog2(NUM_HOST_KEYS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_HOST_KEYS - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [NUM_HOST_KEYS-1:0] held_ff, held_in;
   logic [NUM_HOST_KEYS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic                     issue_ff, issue_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]         rd_pos_ff, rd_pos_in;
   logic [7:0][4:0]          rows_ff, rows_in;
   logic                     out_vld_ff, out_vld_in;
   logic [7:0][4:0]          out_rows_ff;

   logic                     out_load;
   logic                     ram_we;
   logic [IDX_W-1:0]         item_idx;
   logic [ENTRY_W-1:0]       ram_rd;
   logic [ENTRY_W-1:0]       entry;
   logic [1:0]               variant;
   logic                     shift_held, ctrl_held;
   logic [7:0]               mb;
   logic [1:0]               fl;

   assign item_idx  = pop_item.key_index[IDX_W-1:0];
   assign pop_ready = (state_ff == S_IDLE);
   assign ram_we    = pop_valid && pop_ready && (pop_item.op == OP_LOAD);
   assign out_load  = (state_ff == S_DONE) && (!out_vld_ff || rsp_ready);

   kmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_HOST_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (item_idx),
      .wr_data (pop_item.entry),
      .rd_en   (issue_ff),
      .rd_addr (scan_ff),
      .rd_data (ram_rd)
   );

   // pick the variant from held modifiers; absent positions never count
   always_comb begin
      shift_held = 1'b0;
      ctrl_held  = 1'b0;
      for (int i = 0; i < NUM_HOST_KEYS; i++) begin
         if (i == POS_LSHIFT || i == POS_RSHIFT) begin
            shift_held = shift_held | held_ff[i];
         end
         if (i >= POS_CTRL_FIRST && i <= POS_CTRL_LAST) begin
            ctrl_held = ctrl_held | held_ff[i];
         end
      end
      variant = {ctrl_held, shift_held};
   end

   // select mapping byte and flag pair of the entry just read
   always_comb begin
      entry = valid_ff[rd_pos_ff] ? ram_rd : ENTRY_RESET;
      unique case (variant)
         2'd0: begin
            mb = entry[39:32];
            fl = entry[7:6];
         end
         2'd1: begin
            mb = entry[31:24];
            fl = entry[5:4];
         end
         2'd2: begin
            mb = entry[23:16];
            fl = entry[3:2];
         end
         2'd3: begin
            mb = entry[15:8];
            fl = entry[1:0];
         end
         default: begin
            mb = entry[39:32];
            fl = entry[7:6];
         end
      endcase
   end

   // sequencer: apply, scan, hand off
   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      valid_in  = valid_ff;
      scan_in   = scan_ff;
      issue_in  = issue_ff;
      rd_vld_in = 1'b0;
      rd_pos_in = rd_pos_ff;
      rows_in   = rows_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               if (pop_item.op == OP_LOAD) begin
                  valid_in[item_idx] = 1'b1;
               end else if (pop_item.op == OP_KEY) begin
                  held_in[item_idx] = pop_item.key_pressed;
               end
               scan_in  = '0;
               issue_in = 1'b1;
               rows_in  = {8{ROW_IDLE}};
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue reads one entry a cycle
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               rd_pos_in = scan_ff;
               if (scan_ff == IDX_LAST) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            // fold the returned entry into the rows
            if (rd_vld_ff && held_ff[rd_pos_ff]) begin
               for (int r = 0; r < 8; r++) begin
                  if (mb[7:5] == 3'(r)) begin
                     rows_in[r] = rows_in[r] & mb[4:0];
                  end
               end
               rows_in[0][0] = rows_in[0][0] & ~fl[0];
               rows_in[7][1] = rows_in[7][1] & ~fl[1];
            end
            if (rd_vld_ff && !issue_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         held_ff    <= '0;
         valid_ff   <= '0;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         valid_ff   <= valid_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
      scan_ff   <= scan_in;
      rd_pos_ff <= rd_pos_in;
      rows_ff   <= rows_in;
      if (out_load) begin
         out_rows_ff <= rows_ff;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_data.row_0 = out_rows_ff[0];
   assign rsp_data.row_1 = out_rows_ff[1];
   assign rsp_data.row_2 = out_rows_ff[2];
   assign rsp_data.row_3 = out_rows_ff[3];
   assign rsp_data.row_4 = out_rows_ff[4];
   assign rsp_data.row_5 = out_rows_ff[5];
   assign rsp_data.row_6 = out_rows_ff[6];
   assign rsp_data.row_7 = out_rows_ff[7];

   // held keys must not move while a scan is in flight
   a_held_stable_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(held_ff))
      else $error("held keys changed during scan");

   // table writes only happen when an item is taken in idle
   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) && !issue_ff)
      else $error("table write outside idle");

   // read data is folded only while scanning
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_SCAN))
      else $error("read return outside scan");

   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_vld_ff || rsp_ready))
      else $error("result register overwritten");

endmodule

`default_nettype wire

@@ sv/keyboard_matrix_translator_top.sv @@
// ----------------------------------------------------------------------------
// keyboard_matrix_translator_top
// Turns held host keys into eight active-low 5-bit keyboard matrix rows.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one item either loads the five-byte mapping entry of a key
//   (cmd = load) or sets the held state of a key (cmd = key). Indexes at or
//   above NUM_HOST_KEYS change nothing but still produce a result.
//   rsp_* channel: one item per request, carrying all eight rows after the
//   request took effect.
//   Path: an input register, the queue, an apply step, a scan that reads one
//   table entry per cycle from the mapping RAM, and a hand-off to the output
//   register. The scan sets the pace: the back end takes no new item until
//   its scan is through and its rows are handed off. Up to three further
//   items are buffered in the input register and the queue while a scan runs.
//   Reset releases all keys and makes every table entry read as 0xFF
//   mapping bytes with a zero flag byte; no clearing pass is needed.
//   When the receiver stalls, the finished rows wait in the output register;
//   the next scan still runs and then holds until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_matrix_translator_top #(
   parameter int NUM_HOST_KEYS = 105
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire kmt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output kmt_pkg::rsp_type       rsp_data
);

   import kmt_pkg::*;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   kmt_front #(
      .NUM_HOST_KEYS (NUM_HOST_KEYS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   kmt_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   kmt_back #(
      .NUM_HOST_KEYS (NUM_HOST_KEYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
